FILE: hdl/aetf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aetf_pkg
// shared widths, codes and helpers of the admittance energy tank filter
// ----------------------------------------------------------------------------
package aetf_pkg;

  localparam int AXES      = 6;
  localparam int AX_W      = 3;
  localparam int FORCE_W   = 25;
  localparam int TORQUE_W  = 22;
  localparam int OUT_W     = 24;
  localparam int RATIO_W   = 17;
  localparam int TANK_W    = 22;
  localparam int GAIN_W    = 21;
  localparam int FDB_W     = 24;
  localparam int TDB_W     = 21;
  localparam int DT_W      = 17;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 24;

  // serial multiplier and divider sizes
  localparam int MUL_A_W   = 38;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int QUO_W     = 40;
  localparam int NUM_W     = 57;
  localparam int REM_W     = 20;

  localparam int RES_W     = 48;
  localparam int DE_W      = 54;

  localparam logic [TANK_W-1:0] E_THRESHOLD = 22'd655360;
  localparam logic [TANK_W-1:0] E_LIMIT     = 22'd3276800;
  localparam logic signed [31:0] OUT_LIMIT  = 32'sd4194304;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN   = 4'd0,
    CFG_FDB    = 4'd1,
    CFG_TDB    = 4'd2,
    CFG_DT     = 4'd3
  } cfg_idx_t;

  typedef enum logic {
    DIV_BY_40,
    DIV_BY_MASS
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_DOT_F,
    S_DOT_H,
    S_ENERGY,
    S_RATIO,
    S_VEL,
    S_HOLD,
    S_OUT
  } state_t;

  function automatic logic [REM_W:0] div_value(input div_sel_t sel);
    logic [REM_W:0] d;
    unique case (sel)
      DIV_BY_40:   d = 21'd40;
      DIV_BY_MASS: d = 21'd983040;
      default:     d = 21'd40;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    logic [31:0] m;
    m = x[31] ? 32'(-x) : 32'(x);
    return m;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [31:0] v);
    logic signed [31:0] c;
    if (v > OUT_LIMIT) c = OUT_LIMIT;
    else if (v < -OUT_LIMIT) c = -OUT_LIMIT;
    else c = v;
    return c[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/admittance_energy_tank_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// admittance_energy_tank_filter
// six-axis admittance filter with a passivity energy tank, bit-serial datapath
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one wrench sample: three forces
//   and three torques. one transfer in gives exactly one transfer out on the
//   output channel (out_valid/out_ready): six saturated velocities and the
//   hindrance ratio.
//   configuration writes go through cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high, unknown indexes are dropped.
//   each product runs on a shared bit-serial multiplier (30 operations);
//   each velocity step adds a bit-serial divide by the mass (6 operations),
//   and the ratio takes one divide by 40, which runs only when the tank is
//   above its threshold. one sample is worked on at a time.
//   the finished result sits in an output register; the next sample is taken
//   while it waits, and a stalled receiver only holds the sequencer at its
//   final step until the register frees up.
//   reset clears velocity, held wrench, tank energy and ratio and loads the
//   default register values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module admittance_energy_tank_filter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [aetf_pkg::FORCE_W-1:0]  force_x,
  input  wire logic signed [aetf_pkg::FORCE_W-1:0]  force_y,
  input  wire logic signed [aetf_pkg::FORCE_W-1:0]  force_z,
  input  wire logic signed [aetf_pkg::TORQUE_W-1:0] torque_x,
  input  wire logic signed [aetf_pkg::TORQUE_W-1:0] torque_y,
  input  wire logic signed [aetf_pkg::TORQUE_W-1:0] torque_z,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [aetf_pkg::OUT_W-1:0]    vel_x,
  output logic signed [aetf_pkg::OUT_W-1:0]    vel_y,
  output logic signed [aetf_pkg::OUT_W-1:0]    vel_z,
  output logic signed [aetf_pkg::OUT_W-1:0]    rate_x,
  output logic signed [aetf_pkg::OUT_W-1:0]    rate_y,
  output logic signed [aetf_pkg::OUT_W-1:0]    rate_z,
  output logic [aetf_pkg::RATIO_W-1:0]         hindrance_ratio,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [aetf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aetf_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import aetf_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0] sensitivity_gain;
  logic [FDB_W-1:0]  force_deadband;
  logic [TDB_W-1:0]  torque_deadband;
  logic [DT_W-1:0]   time_step;

  // filter state
  logic signed [31:0] velocity_vec [AXES];
  logic signed [31:0] held_wrench  [AXES];
  logic [TANK_W-1:0]  tank_energy;
  logic [RATIO_W-1:0] ratio_reg;

  // per-sample working registers
  logic signed [31:0] raw_in [AXES];
  logic signed [31:0] wrench [AXES];
  logic signed [DE_W-1:0] de_acc;
  logic [AX_W-1:0] ax;
  logic launched;

  state_t state, state_next;

  // serial unit hookup
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic               op_neg;
  logic [PROD_W-1:0]  prod;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num;
  div_sel_t           div_sel;
  logic [QUO_W-1:0]   quo;
  logic               step_done;

  aetf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  aetf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .sel   (div_sel),
    .done  (div_done),
    .quo   (quo)
  );

  // current axis operands
  logic signed [31:0] v_cur, f_cur, h_cur, x_cur;
  logic               angular;
  logic signed [MUL_A_W-1:0] f_wide, damp_v, n_val;
  logic [MUL_A_W-1:0] n_mag;

  assign v_cur   = velocity_vec[ax];
  assign f_cur   = wrench[ax];
  assign h_cur   = held_wrench[ax];
  assign x_cur   = raw_in[ax];
  assign angular = (ax >= AX_W'(3));

  // damping times velocity: 20v on linear axes, 10v on angular ones
  always_comb begin
    f_wide = MUL_A_W'(f_cur);
    if (angular) begin
      damp_v = (MUL_A_W'(v_cur) <<< 3) + (MUL_A_W'(v_cur) <<< 1);
    end else begin
      damp_v = (MUL_A_W'(v_cur) <<< 4) + (MUL_A_W'(v_cur) <<< 2);
    end
    n_val = f_wide - damp_v;
    n_mag = n_val[MUL_A_W-1] ? MUL_A_W'(-n_val) : MUL_A_W'(n_val);
  end

  // operand select
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    unique case (state)
      S_SCALE: begin
        op_a   = MUL_A_W'(abs32(x_cur));
        op_b   = MUL_B_W'(sensitivity_gain);
        op_neg = x_cur[31];
      end
      S_DOT_F: begin
        op_a   = MUL_A_W'(abs32(v_cur));
        op_b   = abs32(f_cur);
        op_neg = v_cur[31] ^ f_cur[31];
      end
      S_DOT_H: begin
        op_a   = MUL_A_W'(abs32(v_cur));
        op_b   = abs32(h_cur);
        op_neg = v_cur[31] ^ h_cur[31];
      end
      S_VEL: begin
        // angular axes have twice the inverse mass
        op_a   = angular ? {n_mag[MUL_A_W-2:0], 1'b0} : n_mag;
        op_b   = MUL_B_W'(time_step);
        op_neg = n_val[MUL_A_W-1];
      end
      S_HOLD: begin
        op_a   = MUL_A_W'(ratio_reg);
        op_b   = abs32(f_cur);
        op_neg = f_cur[31];
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
      end
    endcase
  end

  // product rounded to q15.16, ties away from zero
  logic [PROD_W-1:0]      prod_rnd;
  logic signed [RES_W-1:0] res_p;
  assign prod_rnd = prod + PROD_W'(32768);
  assign res_p = op_neg ? -$signed({1'b0, prod_rnd[RES_W+14:16]})
                        :  $signed({1'b0, prod_rnd[RES_W+14:16]});

  // deadband on the scaled component
  logic [RES_W-1:0] s_mag;
  logic [FDB_W-1:0] db_cur;
  logic             in_band;
  assign s_mag   = res_p[RES_W-1] ? RES_W'(-res_p) : RES_W'(res_p);
  assign db_cur  = angular ? FDB_W'(torque_deadband) : force_deadband;
  assign in_band = (s_mag < RES_W'(db_cur));

  // tank energy update
  logic [RATIO_W:0]       diss_base;
  logic [RATIO_W-1:0]     diss;
  logic signed [DE_W-1:0] e_raw;
  logic [TANK_W-1:0]      e_clamped;
  assign diss_base = (RATIO_W+1)'(65536) - (RATIO_W+1)'(ratio_reg) + (RATIO_W+1)'(2);
  assign diss      = diss_base[RATIO_W:2];
  assign e_raw     = DE_W'(tank_energy) + de_acc - DE_W'(diss);
  always_comb begin
    if (e_raw < 0) e_clamped = '0;
    else if (e_raw > DE_W'(E_LIMIT)) e_clamped = E_LIMIT;
    else e_clamped = e_raw[TANK_W-1:0];
  end

  logic tank_hot;
  assign tank_hot = (tank_energy > E_THRESHOLD);

  // divider input: dividend plus half the divisor for rounding
  always_comb begin
    if (state == S_RATIO) begin
      div_sel = DIV_BY_40;
      div_num = NUM_W'(tank_energy - E_THRESHOLD) + NUM_W'(20);
    end else begin
      div_sel = DIV_BY_MASS;
      div_num = prod[NUM_W-1:0] + NUM_W'(491520);
    end
  end

  // velocity step
  logic signed [QUO_W:0] dv;
  logic signed [QUO_W+1:0] v_sum;
  logic signed [31:0] v_new;
  assign dv    = op_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign v_sum = (QUO_W+2)'(v_cur) + (QUO_W+2)'(dv);
  always_comb begin
    if (v_sum > (QUO_W+2)'(32'sh7FFFFFFF)) v_new = 32'sh7FFFFFFF;
    else if (v_sum < -(QUO_W+2)'(33'sh080000000)) v_new = 32'sh80000000;
    else v_new = v_sum[31:0];
  end

  logic last_ax;
  logic out_free;
  assign last_ax  = (ax == AX_W'(AXES - 1));
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCALE;
      S_SCALE:  if (step_done && last_ax) state_next = S_DOT_F;
      S_DOT_F:  if (step_done) state_next = S_DOT_H;
      S_DOT_H:  if (step_done) state_next = last_ax ? S_ENERGY : S_DOT_F;
      S_ENERGY: state_next = S_RATIO;
      S_RATIO:  if (!tank_hot || step_done) state_next = S_VEL;
      S_VEL:    if (step_done) state_next = S_HOLD;
      S_HOLD:   if (step_done) state_next = last_ax ? S_OUT : S_VEL;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    step_done = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_SCALE, S_DOT_F, S_DOT_H, S_HOLD: begin
        mul_start = !launched;
        step_done = launched && mul_done;
      end
      S_VEL: begin
        mul_start = !launched;
        div_start = mul_done;
        step_done = launched && div_done;
      end
      S_RATIO: begin
        div_start = !launched && tank_hot;
        step_done = launched && div_done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
      ax       <= '0;
    end else begin
      state <= state_next;
      if (mul_start || (state == S_RATIO && div_start)) begin
        launched <= 1'b1;
      end else if (step_done) begin
        launched <= 1'b0;
      end
      // the axis moves on after each scale step, the second step of a dot pair and the hold step
      if (in_valid && in_ready) begin
        ax <= '0;
      end else if (step_done && state != S_DOT_F && state != S_RATIO && state != S_VEL) begin
        ax <= last_ax ? '0 : ax + 1'b1;
      end
    end
  end

  // configuration transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_gain <= GAIN_W'(65536);
      force_deadband   <= '0;
      torque_deadband  <= '0;
      time_step        <= DT_W'(655);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN: sensitivity_gain <= cfg_data[GAIN_W-1:0];
        CFG_FDB:  force_deadband   <= cfg_data[FDB_W-1:0];
        CFG_TDB:  torque_deadband  <= cfg_data[TDB_W-1:0];
        CFG_DT:   time_step        <= cfg_data[DT_W-1:0];
        default:  ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        velocity_vec[i] <= '0;
        held_wrench[i]  <= '0;
      end
      tank_energy <= '0;
      ratio_reg   <= '0;
    end else begin
      if (state == S_ENERGY) tank_energy <= e_clamped;
      if (state == S_RATIO) begin
        if (!tank_hot) ratio_reg <= '0;
        else if (step_done) ratio_reg <= quo[RATIO_W-1:0];
      end
      if (state == S_VEL && step_done) velocity_vec[ax] <= v_new;
      if (state == S_HOLD && step_done) held_wrench[ax] <= res_p[31:0];
    end
  end

  // sample capture, scaled wrench, energy accumulation
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_in[0] <= 32'(force_x);
      raw_in[1] <= 32'(force_y);
      raw_in[2] <= 32'(force_z);
      raw_in[3] <= 32'(torque_x);
      raw_in[4] <= 32'(torque_y);
      raw_in[5] <= 32'(torque_z);
      de_acc    <= '0;
    end else if (step_done) begin
      if (state == S_SCALE) wrench[ax] <= in_band ? 32'sd0 : res_p[31:0];
      if (state == S_DOT_F) de_acc <= de_acc + DE_W'(res_p);
      if (state == S_DOT_H) de_acc <= de_acc - DE_W'(res_p);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      vel_x           <= sat_out(velocity_vec[0]);
      vel_y           <= sat_out(velocity_vec[1]);
      vel_z           <= sat_out(velocity_vec[2]);
      rate_x          <= sat_out(velocity_vec[3]);
      rate_y          <= sat_out(velocity_vec[4]);
      rate_z          <= sat_out(velocity_vec[5]);
      hindrance_ratio <= ratio_reg;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_free) |=> state == S_OUT)
    else $error("sequencer left final step while output held");
  assert property (@(posedge clk) disable iff (rst) ratio_reg <= RATIO_W'(65536))
    else $error("hindrance ratio above one");
  assert property (@(posedge clk) disable iff (rst) tank_energy <= E_LIMIT)
    else $error("tank energy above limit");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> out_valid)
    else $error("result not presented");

endmodule
`default_nettype wire

FILE: hdl/aetf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aetf_mul
// bit-serial unsigned multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module aetf_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [aetf_pkg::MUL_A_W-1:0] a,
  input  wire logic [aetf_pkg::MUL_B_W-1:0] b,
  output logic                             done,
  output logic [aetf_pkg::PROD_W-1:0]      prod
);
  import aetf_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic [PROD_W-1:0]  acc;
  logic [MUL_A_W-1:0] a_hold;
  logic [MUL_B_W-1:0] b_sh;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      a_hold <= a;
      b_sh   <= b;
    end else if (busy) begin
      acc  <= {acc[PROD_W-2:0], 1'b0} +
              (b_sh[MUL_B_W-1] ? PROD_W'(a_hold) : '0);
      b_sh <= {b_sh[MUL_B_W-2:0], 1'b0};
    end
  end

  assign prod = acc;

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier restarted while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while busy");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done longer than one cycle");

endmodule
`default_nettype wire

FILE: hdl/aetf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aetf_div
// restoring divider by a selectable constant, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aetf_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [aetf_pkg::NUM_W-1:0] num,
  input  wire aetf_pkg::div_sel_t        sel,
  output logic                           done,
  output logic [aetf_pkg::QUO_W-1:0]     quo
);
  import aetf_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [REM_W-1:0] rem;
  logic [QUO_W-1:0] q_sh;
  logic [REM_W:0]   dvsr;
  logic [REM_W:0]   trial;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign trial = {rem, q_sh[QUO_W-1]};
  assign ge    = (trial >= dvsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= div_value(sel);
      rem  <= REM_W'(num[NUM_W-1:QUO_W]);
      q_sh <= num[QUO_W-1:0];
    end else if (busy) begin
      rem  <= ge ? REM_W'(trial - dvsr) : trial[REM_W-1:0];
      q_sh <= {q_sh[QUO_W-2:0], ge};
    end
  end

  assign quo = q_sh;

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> rem < dvsr[REM_W-1:0] || dvsr[REM_W])
    else $error("divider remainder out of range");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done longer than one cycle");

endmodule
`default_nettype wire
